// ===== hdl/dqmm_pkg.sv =====
// Shared types, codes and defaults for the double-ended queue with min/max report.
package dqmm_pkg;

  // Default number of entries held
  localparam int unsigned DEPTH_DEF = 64;

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_NOP        = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef logic signed [31:0] data_t;

  // Per-transaction shift/load control broadcast to every cell
  typedef struct packed {
    logic  shr;      // push front: every cell takes its left neighbor
    logic  shl;      // pop front: every cell takes its right neighbor
    logic  ld_back;  // push back: the first free cell loads the value
    data_t value;
  } dqmm_op_t;

  // Partial result handed from back to front along the chain
  typedef struct packed {
    logic  has;
    data_t max;
    data_t min;
    data_t back;
  } dqmm_agg_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SWEEP
  } dqmm_state_t;

endpackage

// ===== hdl/double_ended_queue_min_max.sv =====
// Each accepted transaction starts a max/min/back sweep that walks one cell per cycle
//   from the back of the cell chain to the front; no new transaction is taken until
//   the sweep ends and its result has been loaded into the result register.
// A new transaction is taken while a finished result still waits on out_ready.
// Reset (synchronous, active low) empties the queue and clears the control state;
//   cell contents stay undefined until written.
module double_ended_queue_min_max
  import dqmm_pkg::*;
#(
  parameter int unsigned Depth = DEPTH_DEF,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      in_command,
  input  data_t           in_value,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output data_t           out_front_value,
  output data_t           out_back_value,
  output logic [CntW-1:0] out_count,
  output logic            out_is_empty,
  output data_t           out_max_value,
  output data_t           out_min_value
);

  dqmm_op_t        op;
  logic            load_out;
  logic [CntW-1:0] count;
  logic [1:0]      status;
  data_t           cell_data [Depth];
  dqmm_agg_t       cell_agg  [Depth];
  dqmm_agg_t       agg_tail;

  logic [1:0]      status_r;
  data_t           front_r, back_r, max_r, min_r;
  logic [CntW-1:0] count_r;
  logic            empty_r;

  dqmm_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_value  (in_value),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .op        (op),
    .load_out  (load_out),
    .count     (count),
    .status    (status)
  );

  // Nothing beyond the last cell
  assign agg_tail = '0;

  // Cell chain: position 0 is the front
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    data_t     left_d, right_d;
    dqmm_agg_t agg_in;

    if (i == 0) begin : g_first
      assign left_d = op.value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_d = cell_data[i];
      assign agg_in  = agg_tail;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
      assign agg_in  = cell_agg[i+1];
    end

    dqmm_cell u_cell (
      .clk       (clk),
      .op        (op),
      .left_data (left_d),
      .right_data(right_d),
      .in_use    (count > CntW'(i)),
      .is_last   (count == CntW'(i + 1)),
      .is_tail   (count == CntW'(i)),
      .agg_in    (agg_in),
      .data      (cell_data[i]),
      .agg_out   (cell_agg[i])
    );
  end

  // Result register, loaded once the sweep has reached the front cell
  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r <= status;
      count_r  <= count;
      empty_r  <= (count == '0);
      front_r  <= (count == '0) ? data_t'(0) : cell_data[0];
      back_r   <= cell_agg[0].has ? cell_agg[0].back : data_t'(0);
      max_r    <= cell_agg[0].has ? cell_agg[0].max  : data_t'(0);
      min_r    <= cell_agg[0].has ? cell_agg[0].min  : data_t'(0);
    end
  end

  assign out_status      = status_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;
  assign out_count       = count_r;
  assign out_is_empty    = empty_r;
  assign out_max_value   = max_r;
  assign out_min_value   = min_r;

endmodule

// ===== hdl/dqmm_cell.sv =====
// One queue cell: holds one entry and folds max/min/back toward the front.
module dqmm_cell
  import dqmm_pkg::*;
(
  input  logic      clk,
  input  dqmm_op_t  op,
  input  data_t     left_data,
  input  data_t     right_data,
  input  logic      in_use,
  input  logic      is_last,
  input  logic      is_tail,
  input  dqmm_agg_t agg_in,
  output data_t     data,
  output dqmm_agg_t agg_out
);

  data_t     data_r, data_nxt;
  dqmm_agg_t agg_r, agg_nxt;

  // Entry update for the accepted transaction
  always_comb begin
    data_nxt = data_r;
    priority if (op.shr) begin
      data_nxt = left_data;
    end else if (op.shl) begin
      data_nxt = right_data;
    end else if (op.ld_back && is_tail) begin
      data_nxt = op.value;
    end
  end

  // Fold own entry into what the back neighbor reports
  always_comb begin
    agg_nxt = agg_in;
    if (in_use) begin
      agg_nxt.has  = 1'b1;
      agg_nxt.max  = (agg_in.has && (agg_in.max > data_r)) ? agg_in.max : data_r;
      agg_nxt.min  = (agg_in.has && (agg_in.min < data_r)) ? agg_in.min : data_r;
      agg_nxt.back = is_last ? data_r : agg_in.back;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    agg_r  <= agg_nxt;
  end

  assign data    = data_r;
  assign agg_out = agg_r;

endmodule

// ===== hdl/dqmm_ctrl.sv =====
// Command decode, entry count, status and sweep sequencing for the queue.
module dqmm_ctrl
  import dqmm_pkg::*;
#(
  parameter int unsigned Depth = DEPTH_DEF,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [2:0]      in_command,
  input  data_t           in_value,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output dqmm_op_t        op,
  output logic            load_out,
  output logic [CntW-1:0] count,
  output logic [1:0]      status
);

  dqmm_state_t     state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept, full, empty, sweep_done;
  dqmm_op_t        dec_op;

  assign full       = (count_r == CntW'(Depth));
  assign empty      = (count_r == '0);
  assign sweep_done = (sweep_cnt_r == CntW'(Depth));
  assign accept     = in_valid && in_ready;

  // Command decode against current fill
  always_comb begin
    dec_op       = '0;
    dec_op.value = in_value;
    count_nxt    = count_r;
    status_nxt   = ST_OK;
    unique case (in_command)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          dec_op.shr = 1'b1;
          count_nxt  = count_r + CntW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          dec_op.ld_back = 1'b1;
          count_nxt      = count_r + CntW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          dec_op.shl = 1'b1;
          count_nxt  = count_r - CntW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          count_nxt = count_r - CntW'(1);
        end
      end
      default: begin
        // no operation, unused codes included
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (sweep_done && (!out_valid_r || out_ready)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    op       = '0;
    op.value = in_value;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = dec_op;
      end
      ST_SWEEP: begin
        load_out = sweep_done && (!out_valid_r || out_ready);
      end
      default: begin
      end
    endcase
  end

  // Sweep counter holds at its end while the output is blocked
  always_comb begin
    sweep_cnt_nxt = sweep_cnt_r;
    if (accept) begin
      sweep_cnt_nxt = '0;
    end else if (!sweep_done) begin
      sweep_cnt_nxt = sweep_cnt_r + CntW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sweep_cnt_r <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r  <= count_nxt;
        status_r <= status_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign count     = count_r;
  assign status    = status_r;

endmodule
